FILE: sv/linq_pkg.sv
// shared types for the linear queue with sorted insert
// request, status and cell command codes, cell control bundle
// no dependencies
package linq_pkg;

	typedef enum logic [1:0] {
		REQ_APPEND  = 2'd0,
		REQ_INSERT  = 2'd1,
		REQ_SORTED  = 2'd2,
		REQ_DEQUEUE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_BADPOS    = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_DEQUEUE,
		CMD_SORT,
		CMD_WALK
	} cmd_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_WALK
	} fsm_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] word;
	} linq_ctl_t;

endpackage

FILE: sv/linq_cell.sv
// one queue slot of the cell chain: holds an entry and the sorted-insert token
// depends on linq_pkg
module linq_cell #(
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  linq_pkg::linq_ctl_t ctl,
	input  logic [IDX_W-1:0]    cut,
	input  logic [IDX_W-1:0]    count,
	input  logic [31:0]         below,
	input  logic [31:0]         above,
	input  logic                gt_below,
	input  logic                tok_above,
	output logic [31:0]         entry,
	output logic                gt,
	output logic                tok,
	output logic                placed
);
	import linq_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [31:0] entry_q;
	logic [31:0] entry_d;
	logic        tok_q;
	logic        tok_d;

	// word is smaller than this entry, so the entry has to move up
	assign gt     = $signed(ctl.word) < $signed(entry_q);
	assign entry  = entry_q;
	assign tok    = tok_q;
	assign placed = (ctl.cmd == CMD_WALK) && tok_q && !gt_below;

	always_comb begin
		entry_d = entry_q;
		tok_d   = 1'b0;
		case (ctl.cmd)
			CMD_INSERT: begin
				if (MY_IDX == cut) begin
					entry_d = ctl.word;
				end else if (MY_IDX > cut && MY_IDX <= count) begin
					entry_d = below;
				end
			end
			CMD_DEQUEUE: begin
				entry_d = above;
			end
			CMD_SORT: begin
				tok_d = (MY_IDX == count);
			end
			CMD_WALK: begin
				// token steps down while the lower neighbor is larger than the word
				tok_d = tok_above && gt;
				if (tok_q) begin
					entry_d = gt_below ? below : ctl.word;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
		end
	end

endmodule

FILE: sv/linear_queue_with_sorted_insert_core.sv
// top level of the linear queue with sorted insert: control, apb register, cell chain
// depends on linq_pkg and linq_cell
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+-------------------------------------
//  request   | start, busy (taken: start & !busy)| req_type, item_value, position
//  result    | done (one-cycle strobe)           | out_value, status
//  config    | apb write, pready tied high       | paddr, pwdata, prdata (capacity)
//
// append, positional insert, dequeue and every failed request finish without a walk:
// the result strobes in the cycle after the item is taken and busy stays low.
// sorted insert keeps busy high while a token steps down the cell chain one cell per cycle,
// past each entry larger than the word, until the word is placed.
// live entries sit packed from cell 0 upward, so dequeue shifts the chain down.
// reset clears head, tail and token bits at once and sets capacity to 32.
// results cannot be stalled.
module linear_queue_with_sorted_insert_core #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] item_value,
	input  logic [5:0]         position,
	output logic               done,
	output logic signed [31:0] out_value,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import linq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (IDX_W > 6) ? IDX_W : 6;
	localparam int PW    = LIM_W + 1;
	localparam logic       REG_CAPACITY = 1'b0;
	localparam logic [5:0] CAP_RESET    = 6'd32;

	fsm_t             state_q;
	fsm_t             state_d;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [5:0]       capacity_q;
	logic [31:0]      v_q;
	logic             done_q;
	logic [31:0]      out_value_q;
	stat_t            status_q;

	logic             accept;
	req_t             req;
	logic [IDX_W-1:0] count;
	logic             empty;
	logic [LIM_W-1:0] cap_ext;
	logic [LIM_W-1:0] lim;
	logic             ovf;
	logic [PW-1:0]    pos_ext;
	logic [PW-1:0]    pos_m1;
	logic             badpos;
	stat_t            res_stat;
	logic             ins_ok;
	logic             deq_ok;
	logic             sort_ok;
	logic [IDX_W-1:0] cut_sel;
	linq_ctl_t        ctl;
	logic             placed_any;
	logic             cfg_wr;

	logic [31:0]      cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_gt;
	logic [DEPTH-1:0] cell_tok;
	logic [DEPTH-1:0] cell_placed;

	assign accept  = start && !busy;
	assign req     = req_t'(req_type);
	assign count   = tail_q - head_q;
	assign empty   = (head_q == tail_q);
	assign cap_ext = LIM_W'(capacity_q);
	assign lim     = (cap_ext < LIM_W'(DEPTH)) ? cap_ext : LIM_W'(DEPTH);
	assign ovf     = (LIM_W'(tail_q) >= lim);
	assign pos_ext = PW'(position);
	assign pos_m1  = pos_ext - PW'(1);
	assign badpos  = (position == 6'd0) || (pos_ext > PW'(count) + PW'(1));

	always_comb begin
		res_stat = STAT_OK;
		ins_ok   = 1'b0;
		deq_ok   = 1'b0;
		sort_ok  = 1'b0;
		cut_sel  = count;
		unique case (req)
			REQ_DEQUEUE: begin
				if (empty) res_stat = STAT_UNDERFLOW;
				else deq_ok = 1'b1;
			end
			REQ_APPEND: begin
				if (ovf) res_stat = STAT_OVERFLOW;
				else ins_ok = 1'b1;
			end
			REQ_INSERT: begin
				if (ovf) begin
					res_stat = STAT_OVERFLOW;
				end else if (badpos) begin
					res_stat = STAT_BADPOS;
				end else begin
					ins_ok  = 1'b1;
					cut_sel = pos_m1[IDX_W-1:0];
				end
			end
			REQ_SORTED: begin
				if (ovf) res_stat = STAT_OVERFLOW;
				else sort_ok = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (accept && sort_ok) state_d = FSM_WALK;
			FSM_WALK: if (placed_any) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy     = 1'b0;
		ctl.cmd  = CMD_NONE;
		ctl.word = item_value;
		unique case (state_q)
			FSM_WALK: begin
				busy     = 1'b1;
				ctl.cmd  = CMD_WALK;
				ctl.word = v_q;
			end
			FSM_IDLE: begin
				if (accept) begin
					if (ins_ok) ctl.cmd = CMD_INSERT;
					else if (deq_ok) ctl.cmd = CMD_DEQUEUE;
					else if (sort_ok) ctl.cmd = CMD_SORT;
				end
			end
			default: begin
			end
		endcase
	end

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			logic [31:0] below;
			logic [31:0] above;
			logic        gt_below;
			logic        tok_above;
			if (k > 0) begin : g_lo
				assign below    = cell_entry[k-1];
				assign gt_below = cell_gt[k-1];
			end else begin : g_lo0
				assign below    = '0;
				assign gt_below = 1'b0;
			end
			if (k < DEPTH - 1) begin : g_hi
				assign above     = cell_entry[k+1];
				assign tok_above = cell_tok[k+1];
			end else begin : g_hitop
				assign above     = cell_entry[k];
				assign tok_above = 1'b0;
			end
			linq_cell #(
				.IDX_W    (IDX_W),
				.CELL_IDX (k)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.cut       (cut_sel),
				.count     (count),
				.below     (below),
				.above     (above),
				.gt_below  (gt_below),
				.tok_above (tok_above),
				.entry     (cell_entry[k]),
				.gt        (cell_gt[k]),
				.tok       (cell_tok[k]),
				.placed    (cell_placed[k])
			);
		end
	endgenerate

	assign placed_any = |cell_placed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == FSM_WALK) begin
				if (placed_any) begin
					tail_q <= tail_q + IDX_W'(1);
					done_q <= 1'b1;
				end
			end else if (accept) begin
				done_q <= !sort_ok;
				if (ins_ok) tail_q <= tail_q + IDX_W'(1);
				if (deq_ok) head_q <= head_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_WALK) begin
			out_value_q <= '0;
			status_q    <= STAT_OK;
		end else if (accept) begin
			v_q         <= item_value;
			out_value_q <= deq_ok ? cell_entry[0] : 32'd0;
			status_q    <= res_stat;
		end
	end

	assign done      = done_q;
	assign out_value = out_value_q;
	assign status    = status_q;

	// apb register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {26'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[5:0];
		end
	end

endmodule

FILE: sv/linq_checker.sv
// port-level checks for the linear queue with sorted insert, bound to the top level
// depends on linq_pkg
module linq_assertions (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         req_type,
	input logic               done,
	input logic signed [31:0] out_value,
	input logic [1:0]         status,
	input logic               pready
);
	import linq_pkg::*;

	// every request other than sorted insert answers in the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req_type != REQ_SORTED |=> done)
		else $error("quick request gave no result in the next cycle");

	// only a taken sorted insert makes the block busy
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && req_type == REQ_SORTED))
		else $error("busy rose without a sorted insert item");

	// the sorted insert result ends the busy period
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a sorted insert result");

	// failed requests carry a zero word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> out_value == 32'sd0)
		else $error("failed request returned a nonzero word");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind linear_queue_with_sorted_insert_core linq_assertions u_linq_assertions (.*);

FILE: tb/linq_checker.sv
`timescale 1ns / 100ps
// checker for the linear queue with sorted insert: follows capacity writes on the apb
// port, predicts each request's result and compares it with the done strobe
// depends on linq_pkg
module linq_checker #(
	parameter int         DEPTH    = 32,
	parameter logic [2:0] CAP_ADDR = 3'd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] item_value,
	input  logic [5:0]         position,
	input  logic               done,
	input  logic signed [31:0] out_value,
	input  logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending,
	output int                 n_taken,
	output int                 n_ok,
	output int                 n_overflow,
	output int                 n_underflow,
	output int                 n_badpos,
	output int                 deepest
);
	import linq_pkg::*;

	typedef struct packed {
		req_t               kind;
		logic signed [31:0] value;
		stat_t              st;
	} outcome_t;

	logic signed [31:0] slot_mem [DEPTH];
	int unsigned        head_idx;
	int unsigned        tail_idx;
	logic [5:0]         capacity;
	outcome_t           outcome_q [$];

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("mismatch at %0t: %s: got %0h, expected %0h", $realtime, what, seen, wanted);
		fail_count++;
	endtask

	// updates the queue state for one request and gives the result it must produce
	task automatic apply_request(input req_t kind, input logic signed [31:0] word,
			input logic [5:0] pos, output outcome_t res);
		int unsigned lim;
		int unsigned spot;
		int unsigned k;
		res.kind  = kind;
		res.value = '0;
		res.st    = STAT_OK;
		lim = (capacity < DEPTH) ? capacity : DEPTH;
		if (kind == REQ_DEQUEUE) begin
			if (head_idx >= tail_idx) begin
				res.st = STAT_UNDERFLOW;
			end else begin
				res.value = slot_mem[head_idx];
				head_idx++;
			end
		end else if (tail_idx >= lim) begin
			res.st = STAT_OVERFLOW;
		end else begin
			spot = tail_idx;
			if (kind == REQ_INSERT) begin
				if (pos == 0 || pos > tail_idx - head_idx + 1)
					res.st = STAT_BADPOS;
				else
					spot = head_idx + pos - 1;
			end else if (kind == REQ_SORTED) begin
				// lands after every live entry that is less than or equal to it
				while (spot > head_idx && word < slot_mem[spot - 1])
					spot--;
			end
			if (res.st == STAT_OK) begin
				for (k = tail_idx; k > spot; k--)
					slot_mem[k] = slot_mem[k - 1];
				slot_mem[spot] = word;
				tail_idx++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t fresh;
		if (!arst_n) begin
			head_idx    = 0;
			tail_idx    = 0;
			capacity    = 6'd32;
			outcome_q.delete();
			fail_count  = 0;
			n_taken     = 0;
			n_ok        = 0;
			n_overflow  = 0;
			n_underflow = 0;
			n_badpos    = 0;
			deepest     = 0;
			pending    <= 0;
		end else begin
			// a result always belongs to an item taken at an earlier edge
			if (done) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result with no item outstanding", {30'd0, status}, 32'd0);
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.st)
						report_mismatch($sformatf("status of request kind %0d", want.kind),
							{30'd0, status}, {30'd0, want.st});
					if (out_value !== want.value)
						report_mismatch($sformatf("out_value of request kind %0d", want.kind),
							out_value, want.value);
				end
			end
			if (start && !busy) begin
				apply_request(req_t'(req_type), item_value, position, fresh);
				outcome_q.push_back(fresh);
				n_taken++;
				case (fresh.st)
					STAT_OK:        n_ok++;
					STAT_OVERFLOW:  n_overflow++;
					STAT_UNDERFLOW: n_underflow++;
					default:        n_badpos++;
				endcase
				if (tail_idx - head_idx > deepest)
					deepest = tail_idx - head_idx;
			end
			if (psel && penable && pready && paddr == CAP_ADDR) begin
				if (pwrite)
					capacity = pwdata[5:0];
				else if (prdata !== {26'd0, capacity})
					report_mismatch("capacity readback", prdata, {26'd0, capacity});
			end
			pending <= outcome_q.size();
		end
	end

endmodule

FILE: tb/tb_linear_queue_with_sorted_insert_core.sv
`timescale 1ns / 100ps
// stimulus and verdict for linear_queue_with_sorted_insert_core
// depends on linq_pkg, the core and linq_checker
module tb_linear_queue_with_sorted_insert_core;
	import linq_pkg::*;

	localparam int         DEPTH       = 32;
	localparam logic [2:0] CAP_ADDR    = 3'd0;
	localparam logic [2:0] SPARE_ADDR  = 3'd4;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PHASES      = 6;
	localparam int         PHASE_ITEMS = 150;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic [1:0]         req_type   = REQ_APPEND;
	logic signed [31:0] item_value = '0;
	logic [5:0]         position   = '0;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [2:0]         paddr      = '0;
	logic [31:0]        pwdata     = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] out_value;
	logic [1:0]         status;
	logic [31:0]        prdata;
	logic               pready;

	int fail_count;
	int pending;
	int n_taken;
	int n_ok;
	int n_overflow;
	int n_underflow;
	int n_badpos;
	int deepest;
	int idle_pct = 0;
	int cycles   = 0;

	logic [5:0] phase_cap [PHASES] = '{6'd4, 6'd16, 6'd9, 6'd24, 6'd63, 6'd32};
	int         phase_deq [PHASES] = '{40, 20, 60, 15, 10, 50};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	linear_queue_with_sorted_insert_core #(.DEPTH(DEPTH)) u_top (
		.clk, .arst_n, .start, .busy, .req_type, .item_value, .position,
		.done, .out_value, .status,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	linq_checker #(.DEPTH(DEPTH), .CAP_ADDR(CAP_ADDR)) u_check (
		.clk, .arst_n, .start, .busy, .req_type, .item_value, .position,
		.done, .out_value, .status,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.fail_count, .pending, .n_taken, .n_ok, .n_overflow, .n_underflow,
		.n_badpos, .deepest
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// start stays high from one item to the next unless a gap is drawn
	task automatic send_request(input req_t kind, input logic signed [31:0] word,
			input logic [5:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= kind;
		item_value <= word;
		position   <= pos;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are noise, only the low six hold the capacity
	task automatic set_capacity(input logic [5:0] cap);
		logic [31:0] data;
		wait_quiet();
		data      = $urandom;
		data[5:0] = cap;
		apb_access(1'b1, CAP_ADDR, data);
		apb_access(1'b0, CAP_ADDR, 32'd0);
	endtask

	task automatic random_request(input int deq_pct);
		req_t               kind;
		logic signed [31:0] word;
		logic [5:0]         pos;
		if ($urandom_range(99) < deq_pct) begin
			kind = REQ_DEQUEUE;
		end else begin
			case ($urandom_range(3))
				0:       kind = REQ_APPEND;
				1:       kind = REQ_INSERT;
				default: kind = REQ_SORTED;
			endcase
		end
		// small values give plenty of equal keys for the sorted insert
		case ($urandom_range(7))
			0, 1:    word = $urandom_range(6) - 3;
			2:       word = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: word = $urandom;
		endcase
		pos = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 12));
		send_request(kind, word, pos);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_DEQUEUE, 32'sd0, 6'd0);
		send_request(REQ_INSERT, 32'sd11, 6'd0);
		send_request(REQ_INSERT, 32'sd12, 6'd2);
		send_request(REQ_APPEND, 32'sh7FFFFFFF, 6'd0);
		send_request(REQ_SORTED, 32'sh80000000, 6'd63);
		send_request(REQ_INSERT, 32'sd0, 6'd63);
		send_request(REQ_INSERT, 32'sd0, 6'd3);
		send_request(REQ_INSERT, -32'sd1, 6'd1);
		send_request(REQ_SORTED, 32'sd5, 6'd0);
		send_request(REQ_SORTED, 32'sd5, 6'd0);
		send_request(REQ_INSERT, 32'sh55555555, 6'd4);
		send_request(REQ_SORTED, -32'sd2, 6'd0);
		repeat (3) send_request(REQ_DEQUEUE, 32'sd0, 6'd0);
		// freed head slots must not take part in the compare
		send_request(REQ_SORTED, 32'shAAAAAAAA, 6'd0);
		send_request(REQ_INSERT, 32'sd7, 6'd8);

		// a write to an unmapped address leaves capacity alone
		wait_quiet();
		apb_access(1'b1, SPARE_ADDR, $urandom);
		apb_access(1'b0, CAP_ADDR, 32'd0);

		set_capacity(6'd0);
		send_request(REQ_APPEND, 32'sd1, 6'd1);
		send_request(REQ_INSERT, 32'sd2, 6'd1);
		send_request(REQ_SORTED, 32'sd3, 6'd1);
		send_request(REQ_DEQUEUE, 32'sd0, 6'd0);
		set_capacity(6'd1);
		send_request(REQ_SORTED, 32'sd4, 6'd0);
		send_request(REQ_DEQUEUE, 32'sd0, 6'd0);

		for (int p = 0; p < PHASES; p++) begin
			set_capacity(phase_cap[p]);
			idle_pct = (p < 2) ? 34 : (p < 4) ? 65 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_request(phase_deq[p]);
		end

		wait_quiet();
		repeat (DEPTH + 4) @(posedge clk);
		$display("covered %0d requests: %0d ok, %0d overflow, %0d underflow, %0d bad position",
			n_taken, n_ok, n_overflow, n_underflow, n_badpos);
		$display("queue reached %0d live entries; capacity swept from 0 through 63", deepest);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
